// ===== rtl/lsad_pkg.sv =====
// Shared types and constants for the light sensor averaging lamp controller.
`timescale 1ns / 1ps

package lsad_pkg;

    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned SUM_W       = 23;
    localparam int unsigned WIN_CNT_W   = 7;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned WINDOW_DEF  = 100;

    localparam logic [VALUE_W-1:0] VALUE_MAX         = 16'hFFFF;
    localparam logic [VALUE_W-1:0] THRESHOLD_RST     = 16'd32768;
    localparam logic [VALUE_W-1:0] CONFIRM_TICKS_RST = 16'd900;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS  = 1'd1;

    localparam logic [CHAR_W-1:0] CHAR_START_UP = 8'h42;  // 'B'
    localparam logic [CHAR_W-1:0] CHAR_START_LO = 8'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CHAR_STOP_UP  = 8'h53;  // 'S'
    localparam logic [CHAR_W-1:0] CHAR_STOP_LO  = 8'h73;  // 's'

    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_DARK  = 3'b010,
        PEND_LIGHT = 3'b100
    } pend_t;

    typedef enum logic [2:0] {
        AMB_UNDECIDED = 3'b001,
        AMB_DARK      = 3'b010,
        AMB_LIGHT     = 3'b100
    } amb_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] light_sample;
        logic signed [SAMPLE_W-1:0] knob_sample;
        logic [CHAR_W-1:0]          rx_char;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] dark_threshold;
        logic [VALUE_W-1:0] confirm_ticks;
    } cfg_t;

    typedef struct packed {
        logic               frame_valid;
        logic [VALUE_W-1:0] light_average;
        logic [VALUE_W-1:0] knob_average;
        logic               lamp_on;
        logic [VALUE_W-1:0] lamp_level;
        logic               sampling_on;
    } result_t;

    function automatic logic [VALUE_W-1:0] clamp_sample(input logic signed [SAMPLE_W-1:0] s);
        logic [VALUE_W-1:0] r;
        if (s[SAMPLE_W-1])
            r = '0;
        else if (|s[SAMPLE_W-2:VALUE_W])
            r = VALUE_MAX;
        else
            r = s[VALUE_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] sat_inc(input logic [VALUE_W-1:0] c);
        return (c == VALUE_MAX) ? c : c + VALUE_W'(1);
    endfunction

endpackage

// ===== rtl/lsad_avg.sv =====
// Window average: sum divided by WINDOW through a reciprocal multiply, saturated to 16 bits.
`timescale 1ns / 1ps

module lsad_avg
    import lsad_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic [SUM_W-1:0]   sum,
    output logic [VALUE_W-1:0] avg
);

    // floor(x/W) == (x * (floor(2^S/W)+1)) >> S for x < 2^SUM_W, W <= 2^WIN_CNT_W
    localparam int unsigned SHIFT   = SUM_W + WIN_CNT_W;
    localparam int unsigned RECIP_W = SHIFT + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_VAL = ((64'd1 << SHIFT) / WINDOW) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [PROD_W-1:0]       prod;
    logic [PROD_W-SHIFT-1:0] quot;

    assign prod = PROD_W'(sum) * PROD_W'(RECIP);
    assign quot = prod[PROD_W-1:SHIFT];
    assign avg  = (|quot[PROD_W-SHIFT-1:VALUE_W]) ? VALUE_MAX : quot[VALUE_W-1:0];

endmodule

// ===== rtl/lsad_core.sv =====
// Controller state: accumulation, window averages, debounced dark/light decision, lamp.
`timescale 1ns / 1ps

module lsad_core
    import lsad_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [WIN_CNT_W-1:0] WIN_LAST = WIN_CNT_W'(WINDOW);

    logic                 sampling_reg, sampling_next;
    logic [WIN_CNT_W-1:0] window_count_reg, window_count_next;
    logic [SUM_W-1:0]     light_sum_reg, light_sum_next;
    logic [SUM_W-1:0]     knob_sum_reg, knob_sum_next;
    pend_t                pending_reg, pending_next;
    logic [VALUE_W-1:0]   dark_counter_reg, dark_counter_next;
    logic [VALUE_W-1:0]   bright_counter_reg, bright_counter_next;
    amb_t                 ambient_reg, ambient_next;
    logic                 lamp_enable_reg, lamp_enable_next;
    logic [VALUE_W-1:0]   lamp_intensity_reg, lamp_intensity_next;

    logic [SUM_W-1:0]     light_acc;
    logic [SUM_W-1:0]     knob_acc;
    logic [WIN_CNT_W-1:0] count_inc;
    logic [VALUE_W-1:0]   dark_inc;
    logic [VALUE_W-1:0]   bright_inc;
    logic [VALUE_W-1:0]   light_avg;
    logic [VALUE_W-1:0]   knob_avg;
    logic                 window_end;
    amb_t                 amb_tmp;

    assign light_acc  = light_sum_reg + SUM_W'(clamp_sample(item.light_sample));
    assign knob_acc   = knob_sum_reg + SUM_W'(clamp_sample(item.knob_sample));
    assign count_inc  = window_count_reg + WIN_CNT_W'(1);
    assign window_end = (count_inc == WIN_LAST);
    assign dark_inc   = (pending_reg == PEND_DARK) ? sat_inc(dark_counter_reg)
                                                   : dark_counter_reg;
    assign bright_inc = (pending_reg == PEND_LIGHT) ? sat_inc(bright_counter_reg)
                                                    : bright_counter_reg;

    lsad_avg #(.WINDOW(WINDOW)) u_light_avg (
        .sum (light_acc),
        .avg (light_avg)
    );

    lsad_avg #(.WINDOW(WINDOW)) u_knob_avg (
        .sum (knob_acc),
        .avg (knob_avg)
    );

    always_comb
    begin
        sampling_next       = sampling_reg;
        window_count_next   = window_count_reg;
        light_sum_next      = light_sum_reg;
        knob_sum_next       = knob_sum_reg;
        pending_next        = pending_reg;
        dark_counter_next   = dark_counter_reg;
        bright_counter_next = bright_counter_reg;
        ambient_next        = ambient_reg;
        lamp_enable_next    = lamp_enable_reg;
        lamp_intensity_next = lamp_intensity_reg;
        amb_tmp             = ambient_reg;
        res.frame_valid     = 1'b0;
        res.light_average   = '0;
        res.knob_average    = '0;

        if (item.action)
        begin
            if (item.rx_char inside {CHAR_START_UP, CHAR_START_LO})
            begin
                sampling_next    = 1'b1;
                lamp_enable_next = 1'b1;
                ambient_next     = AMB_UNDECIDED;
            end
            else if (item.rx_char inside {CHAR_STOP_UP, CHAR_STOP_LO})
            begin
                sampling_next       = 1'b0;
                lamp_enable_next    = 1'b0;
                lamp_intensity_next = '0;
                ambient_next        = AMB_UNDECIDED;
            end
        end
        else if (sampling_reg)
        begin
            dark_counter_next   = dark_inc;
            bright_counter_next = bright_inc;
            if (!window_end)
            begin
                window_count_next = count_inc;
                light_sum_next    = light_acc;
                knob_sum_next     = knob_acc;
            end
            else
            begin
                window_count_next = '0;
                light_sum_next    = '0;
                knob_sum_next     = '0;
                res.frame_valid   = 1'b1;
                res.light_average = light_avg;
                res.knob_average  = knob_avg;
                if (light_avg <= cfg.dark_threshold)
                begin
                    pending_next = PEND_DARK;
                    if (dark_inc == cfg.confirm_ticks)
                    begin
                        dark_counter_next   = '0;
                        bright_counter_next = '0;
                        amb_tmp             = AMB_DARK;
                    end
                    if (amb_tmp == AMB_DARK)
                    begin
                        lamp_enable_next    = 1'b1;
                        lamp_intensity_next = knob_avg;
                    end
                end
                else
                begin
                    pending_next = PEND_LIGHT;
                    if (bright_inc == cfg.confirm_ticks)
                    begin
                        dark_counter_next   = '0;
                        bright_counter_next = '0;
                        amb_tmp             = AMB_LIGHT;
                    end
                    if (amb_tmp == AMB_LIGHT)
                    begin
                        lamp_enable_next = 1'b0;
                        pending_next     = PEND_NONE;
                    end
                end
                ambient_next = amb_tmp;
            end
        end

        res.lamp_on     = lamp_enable_next;
        res.lamp_level  = lamp_intensity_next;
        res.sampling_on = sampling_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampling_reg       <= 1'b0;
            window_count_reg   <= '0;
            light_sum_reg      <= '0;
            knob_sum_reg       <= '0;
            pending_reg        <= PEND_NONE;
            dark_counter_reg   <= '0;
            bright_counter_reg <= '0;
            ambient_reg        <= AMB_UNDECIDED;
            lamp_enable_reg    <= 1'b0;
            lamp_intensity_reg <= '0;
        end
        else if (step)
        begin
            sampling_reg       <= sampling_next;
            window_count_reg   <= window_count_next;
            light_sum_reg      <= light_sum_next;
            knob_sum_reg       <= knob_sum_next;
            pending_reg        <= pending_next;
            dark_counter_reg   <= dark_counter_next;
            bright_counter_reg <= bright_counter_next;
            ambient_reg        <= ambient_next;
            lamp_enable_reg    <= lamp_enable_next;
            lamp_intensity_reg <= lamp_intensity_next;
        end
    end

endmodule

// ===== rtl/light_sensor_average_debounce_lamp.sv =====
// Top level: input register, controller core, result register and configuration registers.
// A beat accepted into the input register passes through the core to the result register, which drives the outputs.
// Throughput: one beat per cycle; the core updates all state in one pass per beat.
// The only stall is back pressure from out_ready on the result register.
// Reset: asynchronous, active low; clears all control state, sets the configuration registers to defaults.
// No clearing pass: the block takes beats straight after reset.
`timescale 1ns / 1ps

module light_sensor_average_debounce_lamp
    import lsad_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic signed [SAMPLE_W-1:0] light_sample,
    input  logic signed [SAMPLE_W-1:0] knob_sample,
    input  logic [CHAR_W-1:0]          rx_char,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       frame_valid,
    output logic [VALUE_W-1:0]         light_average,
    output logic [VALUE_W-1:0]         knob_average,
    output logic                       lamp_on,
    output logic [VALUE_W-1:0]         lamp_level,
    output logic                       sampling_on,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic    in_v_reg;
    item_t   item_reg;
    logic    out_v_reg;
    result_t res_reg;
    cfg_t    cfg_reg;
    result_t res;
    logic    advance;
    logic    step;

    assign advance   = !out_v_reg || out_ready;
    assign step      = in_v_reg && advance;
    assign in_ready  = !in_v_reg || advance;
    assign cfg_ready = 1'b1;

    lsad_core #(.WINDOW(WINDOW)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_v_reg <= in_valid;
            if (advance)
                out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action       <= action;
            item_reg.light_sample <= light_sample;
            item_reg.knob_sample  <= knob_sample;
            item_reg.rx_char      <= rx_char;
        end
        if (step)
            res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold <= THRESHOLD_RST;
            cfg_reg.confirm_ticks  <= CONFIRM_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DARK_THRESHOLD: cfg_reg.dark_threshold <= VALUE_W'(cfg_data);
                REG_CONFIRM_TICKS:  cfg_reg.confirm_ticks  <= VALUE_W'(cfg_data);
                default:            ;
            endcase
        end
    end

    assign out_valid     = out_v_reg;
    assign frame_valid   = res_reg.frame_valid;
    assign light_average = res_reg.light_average;
    assign knob_average  = res_reg.knob_average;
    assign lamp_on       = res_reg.lamp_on;
    assign lamp_level    = res_reg.lamp_level;
    assign sampling_on   = res_reg.sampling_on;

endmodule

// ===== rtl/lsad_checker.sv =====
// Port-level checks for the lamp controller, bound to the top level.
`timescale 1ns / 1ps

module lsad_checker
    import lsad_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               frame_valid,
    input logic [VALUE_W-1:0] light_average,
    input logic [VALUE_W-1:0] knob_average,
    input logic               lamp_on,
    input logic [VALUE_W-1:0] lamp_level,
    input logic               sampling_on
);

    // stalled result beat holds its lamp outputs, light average and frame flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lamp_level) && $stable(lamp_on)
            && $stable(light_average) && $stable(frame_valid))
        else $error("result beat changed while stalled");

    a_frame_needs_sampling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> sampling_on)
        else $error("window completed while sampling stopped");

    a_stopped_lamp_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sampling_on |-> !lamp_on && lamp_level == '0)
        else $error("lamp active while sampling stopped");

    a_no_frame_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_valid |-> light_average == '0 && knob_average == '0)
        else $error("averages reported without a completed window");

endmodule

bind light_sensor_average_debounce_lamp lsad_checker u_lsad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_valid   (frame_valid),
    .light_average (light_average),
    .knob_average  (knob_average),
    .lamp_on       (lamp_on),
    .lamp_level    (lamp_level),
    .sampling_on   (sampling_on)
);

// ===== sim/tb_light_sensor_average_debounce_lamp.sv =====
// Testbench for the light sensor averaging lamp controller: directed table, random beats, soak.
`timescale 1ns / 1ps

module tb_light_sensor_average_debounce_lamp;
    import lsad_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_CHAR = 1'b1;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SOAK_TICKS      = 100;

    localparam result_t RES_STOPPED = '0;
    localparam result_t RES_STARTED = '{frame_valid: 1'b0, light_average: '0,
                                        knob_average: '0, lamp_on: 1'b1,
                                        lamp_level: '0, sampling_on: 1'b1};

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } script_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] light_sample;
    logic signed [SAMPLE_W-1:0] knob_sample;
    logic [CHAR_W-1:0]          rx_char;
    logic                       out_valid;
    logic                       out_ready;
    logic                       frame_valid;
    logic [VALUE_W-1:0]         light_average;
    logic [VALUE_W-1:0]         knob_average;
    logic                       lamp_on;
    logic [VALUE_W-1:0]         lamp_level;
    logic                       sampling_on;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // predictor state
    logic                 running      = 1'b0;
    logic [WIN_CNT_W-1:0] win_ticks    = '0;
    logic [SUM_W-1:0]     light_acc    = '0;
    logic [SUM_W-1:0]     knob_acc     = '0;
    pend_t                heading      = PEND_NONE;
    logic [VALUE_W-1:0]   dark_ticks   = '0;
    logic [VALUE_W-1:0]   bright_ticks = '0;
    amb_t                 ambient      = AMB_UNDECIDED;
    logic                 lamp_en      = 1'b0;
    logic [VALUE_W-1:0]   lamp_lvl     = '0;
    logic [VALUE_W-1:0]   dark_thr     = THRESHOLD_RST;
    logic [VALUE_W-1:0]   confirm_at   = CONFIRM_TICKS_RST;

    result_t lamp_results_due [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      idle_cycles  = 0;
    int      tx_gap_pct   = 0;
    int      rx_stall_pct = 0;
    bit      hold_off_req = 1'b0;

    script_row_t opening_script [22] = '{
        '{'{ACT_TICK, 32'sd100, 32'sd100, 8'h00}, 1'b1, RES_STOPPED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, 8'h41}, 1'b1, RES_STOPPED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_STOP_UP}, 1'b1, RES_STOPPED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_START_UP}, 1'b1, RES_STARTED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_START_LO}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, -32'sd1, 32'sd65536, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'sd65535, 32'sd0, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'sd0, 32'sd65535, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'sd65536, -32'sd1, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, 8'hFF}, 1'b1, RES_STARTED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, 8'h00}, 1'b1, RES_STARTED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_STOP_LO}, 1'b1, RES_STOPPED},
        '{'{ACT_TICK, 32'sd65535, 32'sd65535, 8'h00}, 1'b1, RES_STOPPED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_START_LO}, 1'b1, RES_STARTED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_STOP_UP}, 1'b1, RES_STOPPED},
        '{'{ACT_CHAR, 32'sd0, 32'sd0, CHAR_START_UP}, 1'b1, RES_STARTED},
        '{'{ACT_TICK, 32'sd40000, 32'sd20000, 8'h00}, 1'b0, RES_STOPPED},
        '{'{ACT_TICK, 32'sd12345, 32'sd54321, 8'h00}, 1'b0, RES_STOPPED},
        '{'{ACT_TICK, 32'sd32768, 32'sd32767, 8'h00}, 1'b0, RES_STOPPED},
        '{'{ACT_TICK, 32'sd32769, 32'sd1, 8'h00}, 1'b0, RES_STOPPED}
    };

    light_sensor_average_debounce_lamp dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] to_level(input logic signed [SAMPLE_W-1:0] raw);
        if (raw < 0)
            return '0;
        if (raw > 65535)
            return VALUE_MAX;
        return raw[VALUE_W-1:0];
    endfunction

    function automatic result_t predict_lamp_outputs(input item_t it);
        result_t     r;
        int unsigned light_mean;
        int unsigned knob_mean;
        r = '0;
        if (it.action == ACT_CHAR)
        begin
            if (it.rx_char == CHAR_START_UP || it.rx_char == CHAR_START_LO)
            begin
                running = 1'b1;
                lamp_en = 1'b1;
                ambient = AMB_UNDECIDED;
            end
            else if (it.rx_char == CHAR_STOP_UP || it.rx_char == CHAR_STOP_LO)
            begin
                running  = 1'b0;
                lamp_en  = 1'b0;
                lamp_lvl = '0;
                ambient  = AMB_UNDECIDED;
            end
        end
        else if (running)
        begin
            if (heading == PEND_DARK && dark_ticks != VALUE_MAX)
                dark_ticks++;
            else if (heading == PEND_LIGHT && bright_ticks != VALUE_MAX)
                bright_ticks++;
            win_ticks++;
            light_acc += SUM_W'(to_level(it.light_sample));
            knob_acc  += SUM_W'(to_level(it.knob_sample));
            if (win_ticks == WIN_CNT_W'(WINDOW_DEF))
            begin
                win_ticks  = '0;
                light_mean = light_acc / WINDOW_DEF;
                knob_mean  = knob_acc / WINDOW_DEF;
                if (light_mean > VALUE_MAX)
                    light_mean = VALUE_MAX;
                if (knob_mean > VALUE_MAX)
                    knob_mean = VALUE_MAX;
                if (light_mean <= dark_thr)
                begin
                    heading = PEND_DARK;
                    if (dark_ticks == confirm_at)
                    begin
                        dark_ticks   = '0;
                        bright_ticks = '0;
                        ambient      = AMB_DARK;
                    end
                    if (ambient == AMB_DARK)
                    begin
                        lamp_en  = 1'b1;
                        lamp_lvl = VALUE_W'(knob_mean);
                    end
                end
                else
                begin
                    heading = PEND_LIGHT;
                    if (bright_ticks == confirm_at)
                    begin
                        dark_ticks   = '0;
                        bright_ticks = '0;
                        ambient      = AMB_LIGHT;
                    end
                    if (ambient == AMB_LIGHT)
                    begin
                        lamp_en = 1'b0;
                        heading = PEND_NONE;
                    end
                end
                light_acc       = '0;
                knob_acc        = '0;
                r.frame_valid   = 1'b1;
                r.light_average = VALUE_W'(light_mean);
                r.knob_average  = VALUE_W'(knob_mean);
            end
        end
        r.lamp_on     = lamp_en;
        r.lamp_level  = lamp_lvl;
        r.sampling_on = running;
        return r;
    endfunction

    function automatic int pick_bias();
        case ($urandom_range(3, 0))
            0: return int'(dark_thr) - 3000 + int'($urandom_range(6000, 0));
            1: return int'($urandom_range(dark_thr, 0));
            2: return int'($urandom_range(65535, dark_thr));
            default: return int'($urandom_range(65535, 0));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] raw_reading(input int bias);
        int v;
        case ($urandom_range(19, 0))
            0: return $urandom;
            1: return {1'b1, 31'($urandom)};
            2: return $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
            3: return $urandom_range(1, 0) ? 65535 : 0;
            default:
            begin
                v = bias + int'($urandom_range(2000, 0)) - 1000;
                if (v < 0)
                    v = 0;
                else if (v > 65535)
                    v = 65535;
                return v;
            end
        endcase
    endfunction

    function automatic item_t random_item(input int light_bias, input int knob_bias,
                                          input bit ticks_only);
        item_t it;
        it.action       = ACT_TICK;
        it.light_sample = raw_reading(light_bias);
        it.knob_sample  = raw_reading(knob_bias);
        it.rx_char      = CHAR_W'($urandom);
        if (!ticks_only && (!running && $urandom_range(3, 0) == 0))
        begin
            it.action  = ACT_CHAR;
            it.rx_char = $urandom_range(1, 0) ? CHAR_START_UP : CHAR_START_LO;
        end
        else if (!ticks_only && $urandom_range(999, 0) < 15)
        begin
            it.action = ACT_CHAR;
            case ($urandom_range(9, 0))
                0, 1: it.rx_char = $urandom_range(1, 0) ? CHAR_START_UP : CHAR_START_LO;
                2:    it.rx_char = $urandom_range(1, 0) ? CHAR_STOP_UP : CHAR_STOP_LO;
                default: ;
            endcase
        end
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge after the beat is taken and after any random input gap
    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        result_t due;
        action       <= it.action;
        light_sample <= it.light_sample;
        knob_sample  <= it.knob_sample;
        rx_char      <= it.rx_char;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        due = predict_lamp_outputs(it);
        lamp_results_due.push_back(typed ? want : due);
        @(negedge clk);
        if (tx_gap_pct != 0 && $urandom_range(99, 0) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(negedge clk);
        end
    endtask

    // block drains fully before the registers change
    task automatic load_settings(input logic [VALUE_W-1:0] thr, input logic [VALUE_W-1:0] conf);
        in_valid <= 1'b0;
        while (lamp_results_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DARK_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        dark_thr = thr;
        @(negedge clk);
        cfg_index <= REG_CONFIRM_TICKS;
        cfg_data  <= conf;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        confirm_at = conf;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [VALUE_W-1:0] thr, input logic [VALUE_W-1:0] conf,
                             input int beats, input int tx_pct, input int rx_pct,
                             input bit hold);
        int    sent;
        int    light_bias;
        int    knob_bias;
        bit    counts;
        item_t it;
        load_settings(thr, conf);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        hold_off_req = hold;
        light_bias   = pick_bias();
        knob_bias    = $urandom_range(65535, 0);
        sent         = 0;
        while (sent < beats)
        begin
            if ($urandom_range(299, 0) == 0)
            begin
                light_bias = pick_bias();
                knob_bias  = $urandom_range(65535, 0);
            end
            it     = random_item(light_bias, knob_bias, 1'b0);
            counts = (it.action == ACT_CHAR) || running;
            send_beat(it, 1'b0, RES_STOPPED);
            if (counts)
                sent++;
        end
    endtask

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t result %0d: %s expected %0d, got %0d",
                         $time, results_seen, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {frame_valid, light_average, knob_average, lamp_on, lamp_level, sampling_on};
            if (lamp_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result %0d: beat with none expected", $time, results_seen);
            end
            else
            begin
                want = lamp_results_due.pop_front();
                check_field("frame_valid", want.frame_valid, got.frame_valid);
                check_field("light_average", want.light_average, got.light_average);
                check_field("knob_average", want.knob_average, got.knob_average);
                check_field("lamp_on", want.lamp_on, got.lamp_on);
                check_field("lamp_level", want.lamp_level, got.lamp_level);
                check_field("sampling_on", want.sampling_on, got.sampling_on);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_TICK;
        light_sample = '0;
        knob_sample  = '0;
        rx_char      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_DARK_THRESHOLD;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        foreach (opening_script[i])
            send_beat(opening_script[i].beat, opening_script[i].typed, opening_script[i].want);

        run_phase(THRESHOLD_RST, 16'd100, 350, 10, 5, 1'b0);
        run_phase(16'd0, 16'd0, 250, 5, 10, 1'b0);
        run_phase(VALUE_MAX, 16'd200, 300, 0, 0, 1'b1);
        run_phase(VALUE_W'($urandom), VALUE_W'(100 * $urandom_range(5, 1)), 350, 3, 3, 1'b0);
        run_phase(VALUE_W'($urandom), VALUE_W'($urandom), 250, 8, 0, 1'b0);
        run_phase(16'd20000, 16'd300, 250, 0, 0, 1'b0);

        // always dark with the confirm count at its top, back to back ticks to the end
        load_settings(VALUE_MAX, VALUE_MAX);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        send_beat('{ACT_CHAR, 32'sd0, 32'sd0, CHAR_START_UP}, 1'b0, RES_STOPPED);
        repeat (SOAK_TICKS)
            send_beat(random_item($urandom_range(65535, 0), $urandom_range(65535, 0), 1'b1),
                      1'b0, RES_STOPPED);

        in_valid <= 1'b0;
        while (lamp_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
